// ----- hdl/utf8_stream_decoder_core_assert.svh -----
// Assertion macros used by the checker of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define U8SD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 stream decoder: assertion failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define U8SD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 stream decoder: assertion failed");

`endif

// ----- hdl/utf8sd_pkg.sv -----
// Types, constants and the lead byte classifier of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8sd_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int CP_W       = 21;
    localparam int TOTAL_W    = 16;
    localparam int IN_TDATA_W = 8;
    // code_valid + code_point + is_drawable + drawable_total, padded to bytes
    localparam int OUT_TDATA_W = 40;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Pending second byte range checks
    localparam logic [2:0] CHK_NONE = 3'd0;
    localparam logic [2:0] CHK_E0   = 3'd1;
    localparam logic [2:0] CHK_ED   = 3'd2;
    localparam logic [2:0] CHK_F0   = 3'd3;
    localparam logic [2:0] CHK_F4   = 3'd4;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_BAD,
        LEAD_SKIP1,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR
    } utf8sd_lead_t;

    typedef struct packed {
        logic [CP_W-1:0] partial;
        logic [1:0]      owed;
        logic [1:0]      skip;
        logic [2:0]      check;
    } utf8sd_state_t;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] cp;
        logic            drawable;
    } utf8sd_result_t;

    // Classifies a byte seen where a lead byte is expected.
    function automatic utf8sd_lead_t lead_class(input logic [7:0] b);
        utf8sd_lead_t c;
        priority if (b < 8'h80)
            c = LEAD_ASCII;
        else if (b < 8'hC0 || b > 8'hF4)
            c = LEAD_BAD;
        else if (b < 8'hC2)
            c = LEAD_SKIP1;
        else if (b < 8'hE0)
            c = LEAD_TWO;
        else if (b < 8'hF0)
            c = LEAD_THREE;
        else
            c = LEAD_FOUR;
        return c;
    endfunction

endpackage

// ----- hdl/utf8sd_step.sv -----
// Combinational decode of one byte against the current decoder state.
`timescale 1ns / 1ps

module utf8sd_step (
    input  utf8sd_pkg::utf8sd_state_t  state,
    input  logic [7:0]                 data_byte,
    input  logic                       final_byte,
    output utf8sd_pkg::utf8sd_state_t  state_next,
    output utf8sd_pkg::utf8sd_result_t result
);
    import utf8sd_pkg::*;

    logic           done;
    logic           check_fail;
    logic           is_cont;
    logic           valid;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] shifted;
    utf8sd_state_t  nxt;

    assign is_cont = (data_byte >= 8'h80) && (data_byte <= 8'hBF);
    assign shifted = {state.partial[CP_W-7:0], data_byte[5:0]};

    always_comb
    begin
        unique case (state.check)
            CHK_E0:  check_fail = (data_byte >= 8'h80) && (data_byte <= 8'h9F);
            CHK_ED:  check_fail = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
            CHK_F0:  check_fail = (data_byte >= 8'h80) && (data_byte <= 8'h8F);
            CHK_F4:  check_fail = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
            default: check_fail = 1'b0;
        endcase
    end

    always_comb
    begin
        nxt   = state;
        valid = 1'b0;
        done  = 1'b0;
        cp    = '0;

        if (state.skip != 2'd0)
        begin
            nxt.skip = state.skip - 2'd1;
            done     = 1'b1;
        end
        else if (state.check != CHK_NONE)
        begin
            nxt.check = CHK_NONE;
            if (check_fail)
            begin
                valid    = 1'b1;
                cp       = REPLACEMENT_CP;
                nxt.skip = (state.owed != 2'd0) ? state.owed - 2'd1 : 2'd0;
                nxt.owed = 2'd0;
                done     = 1'b1;
            end
        end

        if (!done && state.owed != 2'd0)
        begin
            if (is_cont)
            begin
                nxt.partial = shifted;
                nxt.owed    = state.owed - 2'd1;
                if (state.owed == 2'd1)
                begin
                    valid = 1'b1;
                    cp    = shifted;
                end
            end
            else
            begin
                // Broken sequence: this byte is eaten, the rest is dropped.
                valid    = 1'b1;
                cp       = REPLACEMENT_CP;
                nxt.skip = state.owed - 2'd1;
                nxt.owed = 2'd0;
            end
        end
        else if (!done)
        begin
            unique case (lead_class(data_byte))
                LEAD_ASCII:
                begin
                    valid = 1'b1;
                    cp    = {13'd0, data_byte};
                end
                LEAD_BAD:
                begin
                    valid = 1'b1;
                    cp    = REPLACEMENT_CP;
                end
                LEAD_SKIP1:
                begin
                    valid    = 1'b1;
                    cp       = REPLACEMENT_CP;
                    nxt.skip = 2'd1;
                end
                LEAD_TWO:
                begin
                    nxt.partial = {16'd0, data_byte[4:0]};
                    nxt.owed    = 2'd1;
                end
                LEAD_THREE:
                begin
                    nxt.partial = {17'd0, data_byte[3:0]};
                    nxt.owed    = 2'd2;
                    nxt.check   = (data_byte == 8'hE0) ? CHK_E0 :
                                  (data_byte == 8'hED) ? CHK_ED : CHK_NONE;
                end
                LEAD_FOUR:
                begin
                    nxt.partial = {18'd0, data_byte[2:0]};
                    nxt.owed    = 2'd3;
                    nxt.check   = (data_byte == 8'hF0) ? CHK_F0 :
                                  (data_byte == 8'hF4) ? CHK_F4 : CHK_NONE;
                end
                default:
                begin
                    valid = 1'b1;
                    cp    = REPLACEMENT_CP;
                end
            endcase
        end

        // A string that ends inside a sequence closes it with a replacement.
        if (final_byte && !valid && (nxt.owed != 2'd0 || nxt.check != CHK_NONE))
        begin
            valid = 1'b1;
            cp    = REPLACEMENT_CP;
        end
    end

    assign state_next      = nxt;
    assign result.valid    = valid;
    assign result.cp       = cp;
    assign result.drawable = valid && (cp > 21'd31) && (cp != 21'd127)
                             && ((cp < 21'd128) || (cp > 21'd159));

endmodule

// ----- hdl/utf8_stream_decoder_core.sv -----
// Top level of the UTF-8 stream decoder: byte in, one code point result out.
//
//  Channel   | Beat carries                                   | Handshake
//  ----------+------------------------------------------------+-------------------
//  s_axis    | tdata[7:0] data_byte, tlast final_byte         | s_tvalid/s_tready
//  m_axis    | tdata code_valid, code_point, is_drawable,     | m_tvalid/m_tready
//            | drawable_total; tlast string_end               |
//
// Every input beat produces exactly one output beat, through the input and result registers.
// Throughput is one byte per cycle while m_tready is high: the decode of a byte is one pass
// from the input register through the lead table and shift-or logic into the result register.
// rst_n clears the pipeline valid bits, the decode state and the drawable count.
// A stall on m_tready holds the result register; the input register still
// refills while it is empty, and the input stalls once both stages are full.
`timescale 1ns / 1ps

module utf8_stream_decoder_core #(
    parameter int COUNT_WIDTH = utf8sd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] data_byte
    input  logic [utf8sd_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] code_valid, [21:1] code_point, [22] is_drawable,
    // [38:23] drawable_total, [39] zero
    output logic [utf8sd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                               m_tlast
);
    import utf8sd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
    // The reported total tops out at the 16-bit maximum.
    localparam logic [COUNT_WIDTH-1:0] TotalMax = COUNT_WIDTH'(17'h0FFFF);

    // Input register stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Decode state, carried from one byte to the next
    utf8sd_state_t          state_reg;
    utf8sd_state_t          state_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    // Result register stage
    logic               out_valid_reg;
    logic               out_code_valid_reg;
    logic [CP_W-1:0]    out_cp_reg;
    logic               out_drawable_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               out_last_reg;

    utf8sd_result_t     result;
    logic [TOTAL_W-1:0] total;
    logic               advance;
    logic               out_free;

    // The result register can take a new beat when empty or draining now.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    utf8sd_step u_step (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .final_byte (in_last_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_comb
    begin
        count_next = count_reg;
        if (result.drawable && count_reg != CountMax)
            count_next = count_reg + 1'b1;
        total = (count_next > TotalMax) ? 16'hFFFF : TOTAL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                // The last byte of a string leaves everything cleared.
                state_reg <= in_last_reg ? '0 : state_next;
                count_reg <= in_last_reg ? '0 : count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_code_valid_reg <= result.valid;
            out_cp_reg         <= result.cp;
            out_drawable_reg   <= result.drawable;
            out_total_reg      <= total;
            out_last_reg       <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_total_reg, out_drawable_reg, out_cp_reg,
                       out_code_valid_reg};

endmodule

// ----- hdl/utf8sd_checker.sv -----
// Port-level checker of the UTF-8 stream decoder and its bind to the top level.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_core_assert.svh"

module utf8sd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [utf8sd_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                               s_tlast,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [utf8sd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                               m_tlast
);
    import utf8sd_pkg::*;

    logic                out_beat;
    logic                out_stall;
    logic [TOTAL_W-1:0]  total;
    logic [TOTAL_W-1:0]  prev_total_reg;
    logic                total_step_ok;

    assign out_beat  = m_tvalid && m_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign total     = m_tdata[38:23];

    // Total shown at the previous edge, for the step check below.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_total_reg <= '0;
        else
            prev_total_reg <= total;
    end

    assign total_step_ok = !m_tvalid || (prev_total_reg == 16'hFFFF)
                           || ((total >= prev_total_reg) && (total <= prev_total_reg + 16'd1));

    // A stalled result beat keeps its payload.
    `U8SD_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // No code point means a zero code point that is not drawable.
    `U8SD_ASSERT_NOW(a_empty_code, m_tvalid && !m_tdata[0], m_tdata[21:1] == 21'd0 && !m_tdata[22])

    // A drawable code point is always counted in the running total.
    `U8SD_ASSERT_NOW(a_drawable_counted, m_tvalid && m_tdata[22], total != 16'd0)

    // Inside a string the running total never falls and grows by at most one.
    `U8SD_ASSERT_NEXT(a_total_step, out_beat && !m_tlast, total_step_ok)

endmodule

bind utf8_stream_decoder_core utf8sd_checker u_utf8sd_checker (.*);

// ----- bench/tb_top.sv -----
// Self-checking testbench for the UTF-8 stream decoder core.
`timescale 1ns / 1ps

module tb_top;
    import utf8sd_pkg::*;

    localparam int STALL_LIMIT    = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_BYTES    = 150;

    // One output beat, split into its fields.
    typedef struct packed {
        logic               valid;
        logic [CP_W-1:0]    cp;
        logic               draw;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } code_beat_t;

    // One directed stimulus row; rows with a known answer carry it in want.
    typedef struct {
        logic [7:0] b;
        logic       fin;
        logic       known;
        code_beat_t want;
    } byte_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tlast;

    // Decoder state mirrored by the predictor.
    logic [CP_W-1:0]    dec_partial = '0;
    logic [1:0]         dec_owed = '0;
    logic [1:0]         dec_skip = '0;
    logic [2:0]         dec_check = CHK_NONE;
    logic [TOTAL_W-1:0] dec_count = '0;

    code_beat_t expected_codes[$];
    int error_count = 0;
    int bytes_sent = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_request = 0;
    int idle_cycles = 0;

    utf8_stream_decoder_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic is_drawable_cp(input logic [CP_W-1:0] cp);
        return cp > 21'd31 && cp != 21'd127 && !(cp >= 21'd128 && cp <= 21'd159);
    endfunction

    // Decodes one byte against the mirrored state and returns the beat it causes.
    function automatic code_beat_t decode_byte(input logic [7:0] b, input logic fin);
        code_beat_t r;
        logic done;
        logic fails;
        utf8sd_lead_t kind;
        r = '0;
        done = 1'b0;
        fails = 1'b0;
        if (dec_skip != 2'd0)
        begin
            dec_skip = dec_skip - 2'd1;
            done = 1'b1;
        end
        else if (dec_check != CHK_NONE)
        begin
            case (dec_check)
                CHK_E0:  fails = b inside {[8'h80:8'h9F]};
                CHK_ED:  fails = b inside {[8'hA0:8'hBF]};
                CHK_F0:  fails = b inside {[8'h80:8'h8F]};
                CHK_F4:  fails = b inside {[8'h90:8'hBF]};
                default: fails = 1'b0;
            endcase
            dec_check = CHK_NONE;
            if (fails)
            begin
                r.valid = 1'b1;
                r.cp = REPLACEMENT_CP;
                dec_skip = (dec_owed != 2'd0) ? dec_owed - 2'd1 : 2'd0;
                dec_owed = 2'd0;
                done = 1'b1;
            end
        end

        if (!done && dec_owed != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
                dec_owed = dec_owed - 2'd1;
                if (dec_owed == 2'd0)
                begin
                    r.valid = 1'b1;
                    r.cp = dec_partial;
                end
            end
            else
            begin
                // A non-continuation byte is swallowed; the rest of the sequence is dropped.
                r.valid = 1'b1;
                r.cp = REPLACEMENT_CP;
                dec_skip = dec_owed - 2'd1;
                dec_owed = 2'd0;
            end
        end
        else if (!done)
        begin
            if (b < 8'h80)
                kind = LEAD_ASCII;
            else if (b < 8'hC0 || b > 8'hF4)
                kind = LEAD_BAD;
            else if (b < 8'hC2)
                kind = LEAD_SKIP1;
            else if (b < 8'hE0)
                kind = LEAD_TWO;
            else if (b < 8'hF0)
                kind = LEAD_THREE;
            else
                kind = LEAD_FOUR;
            case (kind)
                LEAD_ASCII:
                begin
                    r.valid = 1'b1;
                    r.cp = {13'd0, b};
                end
                LEAD_BAD:
                begin
                    r.valid = 1'b1;
                    r.cp = REPLACEMENT_CP;
                end
                LEAD_SKIP1:
                begin
                    r.valid = 1'b1;
                    r.cp = REPLACEMENT_CP;
                    dec_skip = 2'd1;
                end
                LEAD_TWO:
                begin
                    dec_partial = {16'd0, b[4:0]};
                    dec_owed = 2'd1;
                end
                LEAD_THREE:
                begin
                    dec_partial = {17'd0, b[3:0]};
                    dec_owed = 2'd2;
                    dec_check = (b == 8'hE0) ? CHK_E0 : (b == 8'hED) ? CHK_ED : CHK_NONE;
                end
                default:
                begin
                    dec_partial = {18'd0, b[2:0]};
                    dec_owed = 2'd3;
                    dec_check = (b == 8'hF0) ? CHK_F0 : (b == 8'hF4) ? CHK_F4 : CHK_NONE;
                end
            endcase
        end

        // A sequence cut off by the end of the string still yields a replacement.
        if (fin && !r.valid && (dec_owed != 2'd0 || dec_check != CHK_NONE))
        begin
            r.valid = 1'b1;
            r.cp = REPLACEMENT_CP;
        end

        r.draw = r.valid && is_drawable_cp(r.cp);
        if (r.draw && dec_count != '1)
            dec_count = dec_count + 16'd1;
        r.total = dec_count;
        r.last = fin;

        if (fin)
        begin
            dec_partial = '0;
            dec_owed = '0;
            dec_skip = '0;
            dec_check = CHK_NONE;
            dec_count = '0;
        end
        return r;
    endfunction

    // Offers one byte, waits for its handshake and records what must come out.
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic known,
                             input code_beat_t want);
        code_beat_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = decode_byte(b, fin);
        expected_codes.insert(expected_codes.size(), known ? want : predicted);
        bytes_sent++;
    endtask

    task automatic send_string(input logic [7:0] q[$]);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1, 1'b0, '0);
    endtask

    // Lowers tvalid, then waits until every outstanding beat has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic void push_utf8(ref logic [7:0] q[$], input int unsigned cp);
        if (cp < 'h80)
            q = {q, cp[7:0]};
        else if (cp < 'h800)
        begin
            q = {q, 8'hC0 | cp[10:6]};
            q = {q, 8'h80 | cp[5:0]};
        end
        else if (cp < 'h10000)
        begin
            q = {q, 8'hE0 | cp[15:12]};
            q = {q, 8'h80 | cp[11:6]};
            q = {q, 8'h80 | cp[5:0]};
        end
        else
        begin
            q = {q, 8'hF0 | cp[20:18]};
            q = {q, 8'h80 | cp[17:12]};
            q = {q, 8'h80 | cp[11:6]};
            q = {q, 8'h80 | cp[5:0]};
        end
    endfunction

    function automatic int unsigned random_cp(input int len);
        int unsigned edges[7] = '{'h7F, 'h80, 'h7FF, 'h800, 'hFFFF, 'h10000, 'h10FFFF};
        if ($urandom_range(9) == 0)
            return edges[$urandom_range(6)];
        case (len)
            1:       return $urandom_range('h7F);
            2:       return $urandom_range('h7FF, 'h80);
            3:       return $urandom_range('hFFFF, 'h800);
            default: return $urandom_range('h10FFFF, 'h10000);
        endcase
    endfunction

    // Mostly well-formed characters with random content, some noise and broken sequences.
    task automatic send_random_string();
        logic [7:0] q[$];
        logic [7:0] part[$];
        logic [7:0] leads[4] = '{8'hE0, 8'hED, 8'hF0, 8'hF4};
        int chars;
        int pick;
        chars = $urandom_range(10, 1);
        repeat (chars)
        begin
            part.delete();
            pick = $urandom_range(9);
            if (pick <= 5)
                push_utf8(part, random_cp($urandom_range(4, 1)));
            else if (pick == 6)
                part = {part, 8'($urandom_range(255))};
            else if (pick == 7)
            begin
                push_utf8(part, random_cp($urandom_range(4, 2)));
                part[$urandom_range(part.size() - 1, 1)] = 8'($urandom_range(255));
            end
            else if (pick == 8)
            begin
                push_utf8(part, random_cp($urandom_range(4, 2)));
                void'(part.pop_back());
            end
            else
            begin
                part = {part, leads[$urandom_range(3)]};
                part = {part, 8'($urandom_range(8'hBF, 8'h80))};
                repeat ($urandom_range(2, 1))
                    part = {part, 8'($urandom_range(8'hBF, 8'h80))};
            end
            q = {q, part};
        end
        send_string(q);
    endtask

    // Receiver: checks every accepted beat and decides tready for the next cycle.
    initial
    begin : sink
        code_beat_t got;
        code_beat_t want;
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.valid = m_tdata[0];
                got.cp    = m_tdata[21:1];
                got.draw  = m_tdata[22];
                got.total = m_tdata[38:23];
                got.last  = m_tlast;
                if (expected_codes.size() == 0)
                    report_mismatch("output beat with no byte waiting for it");
                else
                begin
                    want = expected_codes.pop_front();
                    if (got.valid !== want.valid)
                        report_mismatch($sformatf("code_valid %b, want %b", got.valid,
                                                  want.valid));
                    if (got.cp !== want.cp)
                        report_mismatch($sformatf("code_point %h, want %h", got.cp, want.cp));
                    if (got.draw !== want.draw)
                        report_mismatch($sformatf("is_drawable %b, want %b", got.draw,
                                                  want.draw));
                    if (got.total !== want.total)
                        report_mismatch($sformatf("drawable_total %0d, want %0d", got.total,
                                                  want.total));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("string_end %b, want %b", got.last,
                                                  want.last));
                end
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Ends the run when neither side has moved a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic byte_row_t row(input logic [7:0] b, input int fin);
        byte_row_t r;
        r.b = b;
        r.fin = 1'(fin);
        r.known = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic byte_row_t known_row(input logic [7:0] b, input int fin,
                                            input int valid, input logic [CP_W-1:0] cp,
                                            input int draw, input int total);
        byte_row_t r;
        r.b = b;
        r.fin = 1'(fin);
        r.known = 1'b1;
        r.want = '{valid: 1'(valid), cp: cp, draw: 1'(draw), total: TOTAL_W'(total),
                   last: 1'(fin)};
        return r;
    endfunction

    initial
    begin : stimulus
        byte_row_t rows[$];
        int src_pct[4] = '{0, 53, 0, 20};
        int sink_pct[4] = '{0, 0, 53, 20};
        int phase_start;

        // Extremes, every lead class, the range checks, a bad continuation and
        // strings that end in the middle of a sequence.
        rows = {rows, known_row(8'h00, 0, 1, 21'h0, 0, 0)};
        rows = {rows, known_row(8'h7F, 0, 1, 21'h7F, 0, 0)};
        rows = {rows, known_row(8'h41, 0, 1, 21'h41, 1, 1)};
        rows = {rows, known_row(8'hF5, 0, 1, REPLACEMENT_CP, 1, 2)};
        rows = {rows, known_row(8'hBF, 0, 1, REPLACEMENT_CP, 1, 3)};
        rows = {rows, known_row(8'hC1, 0, 1, REPLACEMENT_CP, 1, 4)};
        rows = {rows, known_row(8'h41, 0, 0, 21'h0, 0, 4)};
        rows = {rows, row(8'hE0, 0)};
        rows = {rows, known_row(8'h80, 0, 1, REPLACEMENT_CP, 1, 5)};
        rows = {rows, row(8'h80, 0)};
        rows = {rows, row(8'hF4, 0)};
        rows = {rows, row(8'h8F, 0)};
        rows = {rows, row(8'hBF, 0)};
        rows = {rows, row(8'hBF, 0)};
        rows = {rows, row(8'hF0, 0)};
        rows = {rows, row(8'h90, 0)};
        rows = {rows, row(8'h80, 0)};
        rows = {rows, row(8'h80, 0)};
        rows = {rows, row(8'hE2, 0)};
        rows = {rows, row(8'h41, 0)};
        rows = {rows, row(8'h82, 0)};
        rows = {rows, row(8'hC2, 0)};
        rows = {rows, row(8'h80, 1)};
        rows = {rows, known_row(8'hF0, 1, 1, REPLACEMENT_CP, 1, 1)};
        rows = {rows, row(8'hE2, 0)};
        rows = {rows, known_row(8'h82, 1, 1, REPLACEMENT_CP, 1, 1)};
        rows = {rows, row(8'hED, 0)};
        rows = {rows, row(8'hA0, 1)};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_byte(rows[i].b, rows[i].fin, rows[i].known, rows[i].want);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = src_pct[p];
            sink_stall_pct = sink_pct[p];
            // The receiver holds off while bytes keep coming, so the core backs up.
            if (p == 0)
                hold_request = LONG_HOLD;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_string();
            wait_drained();
        end

        if (expected_codes.size() != 0)
            report_mismatch($sformatf("%0d output beats never arrived", expected_codes.size()));
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/utf8sd_pkg.sv
hdl/utf8sd_step.sv
hdl/utf8_stream_decoder_core.sv
hdl/utf8sd_checker.sv
bench/tb_top.sv
